// ===== hdl/atc_pkg.sv =====
`default_nettype none
package atc_pkg;
  localparam int MapColsMax = 64;
  localparam int MapRowsMax = 64;
  localparam int ColBits = 6;
  localparam int RowBits = 6;
  localparam int AddrBits = ColBits + RowBits;
  localparam int TileShift = 12;  // 16 pixels << 8 fraction bits
  localparam int PosW = 20;
  localparam int WideW = 24;
  localparam int CfgW = 7;
  localparam logic CfgWidth = 1'b0;
  localparam logic CfgHeight = 1'b1;
  localparam logic ModeWrite = 1'b0;
  localparam logic ModeMove = 1'b1;

  typedef struct packed {
    logic req;
    logic [AddrBits-1:0] addr;
  } rd_req_t;

  // tile index of a signed coordinate, truncating toward zero
  function automatic logic signed [WideW-1:0] tile_of(input logic signed [WideW-1:0] c);
    logic signed [WideW-1:0] q;
    q = c >>> TileShift;
    if (c[WideW-1] && (c[TileShift-1:0] != '0)) q = q + WideW'(1);
    return q;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/atc_map_ram.sv =====
`default_nettype none
module atc_map_ram (
  input  wire clk,
  input  wire we,
  input  wire [atc_pkg::AddrBits-1:0] waddr,
  input  wire wdata,
  input  wire atc_pkg::rd_req_t rd,
  output logic rdata
);
  logic mem [0:(1<<atc_pkg::AddrBits)-1];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (rd.req) rdata <= mem[rd.addr];
  end
endmodule
`default_nettype wire

// ===== hdl/aabb_tilemap_collision_core.sv =====
`default_nettype none
// box versus tile map collision core
// input channel (in_valid/in_ready) carries either a tile write (mode 0) or
// a move query (mode 1); a query yields one result on out_valid/out_ready
// with the resolved centre, writes yield nothing
// the solid map is one 4096 x 1 synchronous ram, one read per cycle
// after reset a clearing pass writes zero to all 4096 entries, one per
// cycle, during which in_ready stays low (config writes still accepted)
// a query walks x then y: per axis a setup state, a lead state, one ram
// read per tile along the leading edge in the scan state, a last state
// for the last read's data, then a done state; an axis with zero motion
// goes straight to done, an empty span or an out of map edge goes from lead to done
// when both axes scan, out_valid is set as the y done state hands over to
// idle, where the next request can be taken
// a write goes to the ram as it is taken; requests are taken while a result
// waits, a query that finishes while the previous result still waits holds
// in its done state until the receiver takes that result
// out of map tiles count as solid and need no read
module aabb_tilemap_collision_core (
  input  wire clk,
  input  wire rst,
  input  wire in_valid,
  output logic in_ready,
  input  wire mode,
  input  wire [5:0] tile_col,
  input  wire [5:0] tile_row,
  input  wire tile_solid,
  input  wire signed [19:0] pos_x,
  input  wire signed [19:0] pos_y,
  input  wire [15:0] half_width,
  input  wire [15:0] half_height,
  input  wire signed [15:0] vel_x,
  input  wire signed [15:0] vel_y,
  output logic out_valid,
  input  wire out_ready,
  output logic signed [19:0] new_pos_x,
  output logic signed [19:0] new_pos_y,
  input  wire cfg_we,
  input  wire [0:0] cfg_index,
  input  wire [6:0] cfg_data
);
  localparam int W = atc_pkg::WideW;
  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SETUP, S_LEAD, S_SCAN, S_LAST, S_DONE}
    state_t;

  state_t state;
  logic [atc_pkg::AddrBits-1:0] clr_cnt;
  logic [6:0] map_width, map_height;
  logic axis_y;                      // 0 while resolving x, 1 for y
  logic signed [W-1:0] x, y, vy;
  logic [15:0] hw, hh;
  logic signed [W-1:0] lead, lo, hi, cur;
  logic neg;                         // moving in negative direction
  logic hit;
  atc_pkg::rd_req_t rd;
  logic rdata, ram_we, ram_wd;
  logic [atc_pkg::AddrBits-1:0] ram_wa;
  logic signed [W-1:0] y_sat;
  logic res_load;                    // result register takes the finished query

  function automatic logic inside_c(input logic signed [W-1:0] c, input logic [6:0] lim);
    return !c[W-1] && (c < W'(lim)) && (c < W'(atc_pkg::MapColsMax));
  endfunction
  function automatic logic signed [W-1:0] sat(input logic signed [W-1:0] v);
    if (v > W'(524287)) return W'(524287);
    if (v < -W'(524288)) return -W'(524288);
    return v;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign res_load = (state == S_DONE) && axis_y && (!out_valid || out_ready);
  assign y_sat = sat(y);
  assign ram_we = (state == S_CLEAR) || (in_valid && in_ready && mode == atc_pkg::ModeWrite);
  assign ram_wa = (state == S_CLEAR) ? clr_cnt : {tile_row, tile_col};
  assign ram_wd = (state == S_CLEAR) ? 1'b0 : tile_solid;

  // scan address: x axis walks rows of column lead, y axis walks columns of row lead
  always_comb begin
    rd.req = (state == S_SCAN);
    rd.addr = axis_y ? {lead[5:0], cur[5:0]} : {cur[5:0], lead[5:0]};
  end

  atc_map_ram u_ram (.clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .rd(rd), .rdata(rdata));

  logic [6:0] lim_lead, lim_span;
  logic signed [W-1:0] hmov, hspan, pspan, snap;
  always_comb begin
    lim_lead = axis_y ? map_height : map_width;
    lim_span = axis_y ? map_width : map_height;
    hmov = axis_y ? W'(hh) : W'(hw);
    hspan = axis_y ? W'(hw) : W'(hh);
    pspan = axis_y ? x : y;
    snap = neg ? ((lead + W'(1)) <<< atc_pkg::TileShift) + hmov
               : (lead <<< atc_pkg::TileShift) - hmov;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      map_width <= 7'd64;
      map_height <= 7'd64;
    end else begin
      if (cfg_we) begin
        if (cfg_index == atc_pkg::CfgWidth) map_width <= cfg_data;
        else map_height <= cfg_data;
      end
      if (res_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready && mode == atc_pkg::ModeMove) begin
            x <= W'(pos_x) + W'(vel_x);
            y <= W'(pos_y);
            vy <= W'(vel_y);
            hw <= half_width;
            hh <= half_height;
            neg <= vel_x[15];
            axis_y <= 1'b0;
            state <= (vel_x == '0) ? S_DONE : S_SETUP;
          end
        end
        S_SETUP: begin
          // span and leading tile for the current axis
          lo <= atc_pkg::tile_of(pspan - hspan);
          hi <= atc_pkg::tile_of(pspan + hspan - W'(1));
          lead <= neg ? atc_pkg::tile_of((axis_y ? y : x) - hmov)
                      : atc_pkg::tile_of((axis_y ? y : x) + hmov - W'(1));
          state <= S_LEAD;
        end
        S_LEAD: begin
          cur <= lo;
          hit <= 1'b0;
          if (lo > hi) state <= S_DONE;
          else if (!inside_c(lead, lim_lead) || !inside_c(lo, lim_span)
                   || !inside_c(hi, lim_span)) begin
            if (axis_y) y <= snap; else x <= snap;
            state <= S_DONE;
          end else state <= S_SCAN;
        end
        S_SCAN: begin
          if (cur == hi) state <= S_LAST;
          cur <= cur + W'(1);
          if (rdata && cur != lo) hit <= 1'b1;
        end
        S_LAST: begin
          if (hit || rdata) begin
            if (axis_y) y <= snap; else x <= snap;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!axis_y) begin
            x <= sat(x);
            y <= y + vy;
            axis_y <= 1'b1;
            neg <= vy[W-1];
            state <= (vy == '0) ? S_DONE : S_SETUP;
          end else if (res_load) begin
            new_pos_x <= x[19:0];
            new_pos_y <= y_sat[19:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a waiting result stays up until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped under stall");
  a_res: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(new_pos_x) && $stable(new_pos_y)))
    else $error("result changed under stall");
  a_clr: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready) else $error("ready during clear");
endmodule
`default_nettype wire

// ===== verif/aabb_tilemap_collision_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aabb_tilemap_collision_checker (
  input  wire clk,
  input  wire rst,
  input  wire in_valid,
  input  wire in_ready,
  input  wire mode,
  input  wire [5:0] tile_col,
  input  wire [5:0] tile_row,
  input  wire tile_solid,
  input  wire signed [19:0] pos_x,
  input  wire signed [19:0] pos_y,
  input  wire [15:0] half_width,
  input  wire [15:0] half_height,
  input  wire signed [15:0] vel_x,
  input  wire signed [15:0] vel_y,
  input  wire out_valid,
  input  wire out_ready,
  input  wire signed [19:0] new_pos_x,
  input  wire signed [19:0] new_pos_y,
  input  wire cfg_we,
  input  wire [0:0] cfg_index,
  input  wire [6:0] cfg_data,
  output int fail_count,
  output int moves_pending
);
  localparam longint TileUnits = longint'(1) << atc_pkg::TileShift;
  localparam longint PosHi = 524287;
  localparam longint PosLo = -524288;
  localparam int PosW = atc_pkg::PosW;
  localparam int ColsMax = atc_pkg::MapColsMax;
  localparam int RowsMax = atc_pkg::MapRowsMax;

  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
  } centre_t;

  bit solid_tiles [0:ColsMax*RowsMax-1];
  logic [atc_pkg::CfgW-1:0] cols_used;
  logic [atc_pkg::CfgW-1:0] rows_used;
  centre_t resolved_q[$];

  function automatic longint tile_idx(longint c);
    return c / TileUnits;
  endfunction

  function automatic bit col_in(longint c);
    return c >= 0 && c < longint'(cols_used) && c < ColsMax;
  endfunction

  function automatic bit row_in(longint r);
    return r >= 0 && r < longint'(rows_used) && r < RowsMax;
  endfunction

  function automatic bit col_hit(longint col, longint lo, longint hi);
    if (lo > hi) return 1'b0;
    if (!col_in(col) || !row_in(lo) || !row_in(hi)) return 1'b1;
    for (longint r = lo; r <= hi; r++)
      if (solid_tiles[r*ColsMax + col]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit row_hit(longint row, longint lo, longint hi);
    if (lo > hi) return 1'b0;
    if (!row_in(row) || !col_in(lo) || !col_in(hi)) return 1'b1;
    for (longint c = lo; c <= hi; c++)
      if (solid_tiles[row*ColsMax + c]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > PosHi) return PosHi;
    if (v < PosLo) return PosLo;
    return v;
  endfunction

  function automatic centre_t resolve_move(logic signed [19:0] px, logic signed [19:0] py,
                                           logic [15:0] hwi, logic [15:0] hhi,
                                           logic signed [15:0] vxi, logic signed [15:0] vyi);
    longint x, y, hw, hh, vx, vy, lo, hi, lead;
    centre_t r;
    x = px; y = py; hw = hwi; hh = hhi; vx = vxi; vy = vyi;
    x += vx;
    lo = tile_idx(y - hh);
    hi = tile_idx(y + hh - 1);
    if (vx > 0) begin
      lead = tile_idx(x + hw - 1);
      if (col_hit(lead, lo, hi)) x = lead * TileUnits - hw;
    end else if (vx < 0) begin
      lead = tile_idx(x - hw);
      if (col_hit(lead, lo, hi)) x = (lead + 1) * TileUnits + hw;
    end
    x = clamp_pos(x);
    y += vy;
    lo = tile_idx(x - hw);
    hi = tile_idx(x + hw - 1);
    if (vy > 0) begin
      lead = tile_idx(y + hh - 1);
      if (row_hit(lead, lo, hi)) y = lead * TileUnits - hh;
    end else if (vy < 0) begin
      lead = tile_idx(y - hh);
      if (row_hit(lead, lo, hi)) y = (lead + 1) * TileUnits + hh;
    end
    y = clamp_pos(y);
    r.x = x[PosW-1:0];
    r.y = y[PosW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    centre_t got;
    int errs;
    errs = 0;
    if (rst) begin
      foreach (solid_tiles[i]) solid_tiles[i] = 1'b0;
      cols_used = 7'd64;
      rows_used = 7'd64;
      resolved_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == atc_pkg::CfgWidth) cols_used = cfg_data;
        else rows_used = cfg_data;
      end
      if (in_valid && in_ready) begin
        if (mode == atc_pkg::ModeWrite) solid_tiles[{tile_row, tile_col}] = tile_solid;
        else resolved_q.push_back(resolve_move(pos_x, pos_y, half_width, half_height,
                                               vel_x, vel_y));
      end
      if (out_valid && out_ready) begin
        if (resolved_q.size() == 0) begin
          $error("result with no move request pending");
          errs++;
        end else begin
          got = resolved_q.pop_front();
          if (new_pos_x !== got.x) begin
            $error("new_pos_x expected %0d actual %0d", got.x, new_pos_x);
            errs++;
          end
          if (new_pos_y !== got.y) begin
            $error("new_pos_y expected %0d actual %0d", got.y, new_pos_y);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    moves_pending <= resolved_q.size();
  end
endmodule
`default_nettype wire

// ===== verif/aabb_tilemap_collision_core_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aabb_tilemap_collision_core_tb;

  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 200;  // covers the longest query walk

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = atc_pkg::ModeWrite;
  logic [5:0] tile_col = '0;
  logic [5:0] tile_row = '0;
  logic tile_solid = 1'b0;
  logic signed [19:0] pos_x = '0;
  logic signed [19:0] pos_y = '0;
  logic [15:0] half_width = '0;
  logic [15:0] half_height = '0;
  logic signed [15:0] vel_x = '0;
  logic signed [15:0] vel_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [19:0] new_pos_x;
  logic signed [19:0] new_pos_y;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = atc_pkg::CfgWidth;
  logic [6:0] cfg_data = '0;

  int fail_count;
  int moves_pending;
  int cycle_count = 0;
  int send_idle = 0;     // percent of cycles the sender holds back
  int recv_idle = 0;     // percent of cycles the receiver holds back
  bit hold_request = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left = 0;

  always #2 clk = ~clk;

  aabb_tilemap_collision_core dut (.*);

  aabb_tilemap_collision_checker u_checker (.*);

  // receiver side: random back-pressure plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_request && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // offer one request and wait for it to be taken; valid stays up afterwards
  task automatic push_request(logic m, logic [5:0] c, logic [5:0] r, logic s,
                              logic [19:0] px, logic [19:0] py,
                              logic [15:0] hw, logic [15:0] hh,
                              logic [15:0] vx, logic [15:0] vy);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m; tile_col <= c; tile_row <= r; tile_solid <= s;
    pos_x <= px; pos_y <= py; half_width <= hw; half_height <= hh;
    vel_x <= vx; vel_y <= vy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic put_tile(logic [5:0] c, logic [5:0] r, logic s);
    push_request(atc_pkg::ModeWrite, c, r, s, 20'($urandom), 20'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic put_move(logic [19:0] px, logic [19:0] py, logic [15:0] hw,
                          logic [15:0] hh, logic [15:0] vx, logic [15:0] vy);
    push_request(atc_pkg::ModeMove, 6'($urandom), 6'($urandom), 1'($urandom),
                 px, py, hw, hh, vx, vy);
  endtask

  // let every query come back, then let the block settle
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (moves_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_map_size(logic [6:0] w, logic [6:0] h);
    drain_block();
    cfg_we <= 1'b1; cfg_index <= atc_pkg::CfgWidth; cfg_data <= w;
    @(posedge clk);
    cfg_index <= atc_pkg::CfgHeight; cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly tile edits and in-map moves with sizes of a tile or two
  task automatic random_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      put_tile(6'($urandom), 6'($urandom), $urandom_range(99) < 35);
    end else if (pick < 85) begin
      put_move(20'($urandom_range(262143)), 20'($urandom_range(262143)),
               16'($urandom_range(6000)), 16'($urandom_range(6000)),
               16'($urandom_range(12000) - 6000), 16'($urandom_range(12000) - 6000));
    end else if (pick < 92) begin
      // near the map origin, where negative coordinates within one tile of it truncate to tile 0
      put_move(20'($urandom_range(16000) - 8000), 20'($urandom_range(16000) - 8000),
               16'($urandom_range(3000)), 16'($urandom_range(3000)),
               16'($urandom_range(12000) - 6000), 16'($urandom_range(12000) - 6000));
    end else begin
      put_move(20'($urandom), 20'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: corner tiles, zero-size boxes, zero motion, saturation
    put_tile(6'd0, 6'd0, 1'b1);
    put_tile(6'd63, 6'd63, 1'b1);
    put_tile(6'd5, 6'd3, 1'b1);
    put_tile(6'd6, 6'd3, 1'b0);
    put_move(20'sd18432, 20'sd14336, 16'd1024, 16'd1024, 16'sd2048, 16'sd0);
    put_move(20'sd26624, 20'sd14336, 16'd1024, 16'd1024, -16'sd4000, 16'sd0);
    put_move(20'sd22528, 20'sd8192, 16'd1024, 16'd1024, 16'sd0, 16'sd6000);
    put_move(20'sd40000, 20'sd40000, 16'd0, 16'd0, 16'sd32767, -16'sd32768);
    put_move(20'sd40000, 20'sd40000, 16'd0, 16'd2000, 16'sd0, 16'sd0);
    put_move(20'sd524287, 20'sd524287, 16'd65535, 16'd65535, 16'sd32767, 16'sd32767);
    put_move(-20'sd524288, -20'sd524288, 16'd65535, 16'd65535, -16'sd32768, -16'sd32768);
    put_move(-20'sd100, -20'sd100, 16'd50, 16'd50, 16'sd30, 16'sd30);
    put_move(20'sd4500, 20'sd4500, 16'd300, 16'd300, -16'sd1000, -16'sd1000);
    put_move(20'sd259000, 20'sd259000, 16'd2000, 16'd2000, 16'sd9000, 16'sd9000);
    put_move(20'sd100000, 20'sd100000, 16'd65535, 16'd10, 16'sd100, -16'sd100);
    put_move(20'sd100000, 20'sd100000, 16'd1, 16'd1, 16'sd1, -16'sd1);

    // map size extremes, including sizes beyond storage and zero
    set_map_size(7'd1, 7'd1);
    put_move(20'sd2048, 20'sd2048, 16'd512, 16'd512, 16'sd3000, 16'sd3000);
    put_move(20'sd2048, 20'sd2048, 16'd512, 16'd512, -16'sd3000, -16'sd3000);
    set_map_size(7'd0, 7'd0);
    put_move(20'sd2048, 20'sd2048, 16'd512, 16'd512, 16'sd100, 16'sd100);
    set_map_size(7'd127, 7'd127);
    put_move(20'sd258000, 20'sd258000, 16'd1000, 16'd1000, 16'sd8000, 16'sd8000);
    set_map_size(7'd64, 7'd64);

    send_idle = 20; recv_idle = 88;
    repeat (280) random_request();
    set_map_size(7'd17, 7'd40);
    send_idle = 88; recv_idle = 20;
    repeat (280) random_request();
    set_map_size(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
    send_idle = 0; recv_idle = 0;
    repeat (50) random_request();
    hold_request = 1'b1;  // sender keeps offering while the receiver holds off
    repeat (240) random_request();
    set_map_size(7'd64, 7'd64);
    repeat (40) random_request();
    drain_block();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
